/* rtl/core/spa_pkg.sv */
// Shared types and constants for the slot pool allocator.
// No dependencies; imported by the controller, datapath and top level.
package spa_pkg;

   localparam int BLOCKS     = 1024;
   localparam int BLOCK_BITS = $clog2(BLOCKS);
   localparam int FULL_BITS  = BLOCK_BITS + 1;
   localparam int SLOTS      = 16;
   localparam int SLOT_BITS  = 4;
   localparam int GEN_BITS   = 8;
   localparam int CODE_BITS  = 22;

   localparam logic [BLOCK_BITS-1:0] BLOCK_LAST = BLOCK_BITS'(BLOCKS - 1);
   localparam logic [SLOTS-1:0]      ALL_IDLE   = '1;

   localparam logic [1:0] OP_OPEN   = 2'd0;
   localparam logic [1:0] OP_CLOSE  = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic CSR_GEN_ENABLE = 1'b0;
   localparam logic CSR_MAX_CODE   = 1'b1;

   typedef logic [SLOTS-1:0][GEN_BITS-1:0] gen_row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic fetch;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_busy;
   } stat_type;

endpackage

/* rtl/core/spa_ctrl.sv */
// Sequencer for the slot pool allocator: clearing pass, accept, fetch, execute.
// Depends on spa_pkg; drives the datapath command struct.
module spa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  spa_pkg::stat_type stat,
   output spa_pkg::cmd_type  cmd
);
   import spa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
         end
         ST_EXEC: begin
            cmd.commit = !stat.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/core/spa_datapath.sv */
// Datapath: mask, generation and block-order memories, fill count, config
// registers, open/close/lookup logic and the result register. Depends on spa_pkg.
module spa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  spa_pkg::cmd_type              cmd,
   output spa_pkg::stat_type             stat,
   input  logic [1:0]                    req_opcode,
   input  logic [spa_pkg::CODE_BITS-1:0]  req_room_code,
   input  logic [spa_pkg::BLOCK_BITS-1:0] req_close_block,
   input  logic [spa_pkg::SLOT_BITS-1:0]  req_close_slot,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [spa_pkg::CODE_BITS-1:0]  csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [spa_pkg::BLOCK_BITS-1:0] rsp_block_index,
   output logic [spa_pkg::SLOT_BITS-1:0]  rsp_slot_index,
   output logic [spa_pkg::GEN_BITS-1:0]   rsp_generation,
   output logic [spa_pkg::CODE_BITS-1:0]  rsp_code_out,
   output logic                          rsp_block_acquired,
   output logic                          rsp_block_released
);
   import spa_pkg::*;

   logic [SLOTS-1:0]      mask_mem_ff  [BLOCKS];
   gen_row_type           gen_mem_ff   [BLOCKS];
   logic [BLOCK_BITS-1:0] order_mem_ff [BLOCKS];

   logic                  gen_en_ff;
   logic [CODE_BITS-1:0]  max_code_ff;
   logic [BLOCK_BITS-1:0] clr_cnt_ff;
   logic [FULL_BITS-1:0]  full_count_ff, full_count_in;

   logic [1:0]            op_ff;
   logic [CODE_BITS-1:0]  code_ff;
   logic [BLOCK_BITS-1:0] cblk_ff;
   logic [SLOT_BITS-1:0]  cslot_ff;
   logic [BLOCK_BITS-1:0] order_q_ff;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [SLOTS-1:0]      mask_q_ff;
   gen_row_type           gen_q_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            status_ff, status_in;
   logic [BLOCK_BITS-1:0] oblk_ff, oblk_in;
   logic [SLOT_BITS-1:0]  oslot_ff, oslot_in;
   logic [GEN_BITS-1:0]   ogen_ff, ogen_in;
   logic [CODE_BITS-1:0]  ocode_ff, ocode_in;
   logic                  acq_ff, acq_in;
   logic                  rel_ff, rel_in;

   logic                  exhausted;
   logic [SLOT_BITS-1:0]  low_slot;
   logic [SLOT_BITS-1:0]  cur_slot;
   logic [GEN_BITS-1:0]   cur_gen;
   logic [GEN_BITS-1:0]   gen_inc;
   logic [SLOTS-1:0]      mask_new;
   logic [SLOTS-1:0]      close_mask;
   gen_row_type           gen_row_new;
   logic                  mask_we, gen_we, order_we;
   logic [BLOCK_BITS-1:0] push_addr;

   assign stat.clear_done = (clr_cnt_ff == BLOCK_LAST);
   assign stat.out_busy   = rsp_valid_ff && rsp_stall;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_en_ff   <= 1'b1;
         max_code_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GEN_ENABLE: gen_en_ff   <= csr_wdata[0];
            CSR_MAX_CODE:   max_code_ff <= csr_wdata;
            default:        gen_en_ff   <= gen_en_ff;
         endcase
      end
   end

   // clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear && !stat.clear_done) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // request word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_opcode;
         code_ff  <= req_room_code;
         cblk_ff  <= req_close_block;
         cslot_ff <= req_close_slot;
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_OPEN:  blk_in = order_q_ff;
         OP_CLOSE: blk_in = cblk_ff;
         default:  blk_in = code_ff[SLOT_BITS +: BLOCK_BITS];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) blk_ff <= blk_in;
   end

   // block order memory
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         order_mem_ff[clr_cnt_ff] <= clr_cnt_ff;
      end else if (order_we) begin
         order_mem_ff[push_addr] <= blk_ff;
      end
      if (cmd.accept) order_q_ff <= order_mem_ff[full_count_ff[BLOCK_BITS-1:0]];
   end

   // idle mask memory
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mask_mem_ff[clr_cnt_ff] <= ALL_IDLE;
      end else if (mask_we) begin
         mask_mem_ff[blk_ff] <= mask_new;
      end
      if (cmd.fetch) mask_q_ff <= mask_mem_ff[blk_in];
   end

   // generation memory, one row of 16 slots per block
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         gen_mem_ff[clr_cnt_ff] <= '0;
      end else if (gen_we) begin
         gen_mem_ff[blk_ff] <= gen_row_new;
      end
      if (cmd.fetch) gen_q_ff <= gen_mem_ff[blk_in];
   end

   always_comb begin
      low_slot = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_q_ff[i]) low_slot = SLOT_BITS'(i);
      end
   end

   assign exhausted = (full_count_ff == FULL_BITS'(BLOCKS));
   assign push_addr = BLOCK_BITS'(full_count_ff - 1'b1);

   always_comb begin
      unique case (op_ff)
         OP_OPEN:  cur_slot = low_slot;
         OP_CLOSE: cur_slot = cslot_ff;
         default:  cur_slot = code_ff[SLOT_BITS-1:0];
      endcase
   end

   assign cur_gen    = gen_q_ff[cur_slot];
   assign close_mask = mask_q_ff | (SLOTS'(1) << cur_slot);

   always_comb begin
      gen_inc = cur_gen + 1'b1;
      if ({gen_inc, blk_ff, cur_slot} > max_code_ff) gen_inc = '0;
   end

   // operation logic
   always_comb begin
      full_count_in = full_count_ff;
      mask_new      = mask_q_ff;
      gen_row_new   = gen_q_ff;
      mask_we       = 1'b0;
      gen_we        = 1'b0;
      order_we      = 1'b0;
      status_in     = STATUS_MISS;
      oblk_in       = '0;
      oslot_in      = '0;
      ogen_in       = '0;
      ocode_in      = '0;
      acq_in        = 1'b0;
      rel_in        = 1'b0;
      unique case (op_ff)
         OP_OPEN: begin
            if (exhausted || mask_q_ff == '0) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_OK;
               mask_new  = mask_q_ff & (mask_q_ff - 1'b1);
               mask_we   = 1'b1;
               if (mask_new == '0) full_count_in = full_count_ff + 1'b1;
               acq_in   = (mask_q_ff == ALL_IDLE);
               oblk_in  = blk_ff;
               oslot_in = cur_slot;
               ogen_in  = cur_gen;
               ocode_in = {cur_gen, blk_ff, cur_slot};
            end
         end
         OP_CLOSE: begin
            oblk_in  = blk_ff;
            oslot_in = cur_slot;
            ogen_in  = cur_gen;
            if (!mask_q_ff[cur_slot]) begin
               status_in = STATUS_OK;
               if (gen_en_ff) begin
                  gen_row_new[cur_slot] = gen_inc;
                  gen_we  = 1'b1;
                  ogen_in = gen_inc;
               end
               if (mask_q_ff == '0 && full_count_ff != '0) begin
                  full_count_in = full_count_ff - 1'b1;
                  order_we      = 1'b1;
               end
               mask_new = close_mask;
               mask_we  = 1'b1;
               rel_in   = (close_mask == ALL_IDLE);
            end
         end
         OP_LOOKUP: begin
            oblk_in  = blk_ff;
            oslot_in = cur_slot;
            ogen_in  = code_ff[CODE_BITS-1 -: GEN_BITS];
            if (!mask_q_ff[cur_slot] && ogen_in == cur_gen) status_in = STATUS_OK;
         end
         default: begin
            status_in = STATUS_MISS;
         end
      endcase
      if (!cmd.commit) begin
         full_count_in = full_count_ff;
         mask_we       = 1'b0;
         gen_we        = 1'b0;
         order_we      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_count_ff <= '0;
      end else begin
         full_count_ff <= full_count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         oblk_ff   <= oblk_in;
         oslot_ff  <= oslot_in;
         ogen_ff   <= ogen_in;
         ocode_ff  <= ocode_in;
         acq_ff    <= acq_in;
         rel_ff    <= rel_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_block_index    = oblk_ff;
   assign rsp_slot_index     = oslot_ff;
   assign rsp_generation     = ogen_ff;
   assign rsp_code_out       = ocode_ff;
   assign rsp_block_acquired = acq_ff;
   assign rsp_block_released = rel_ff;

endmodule

/* rtl/core/slot_pool_allocator_with_generations_top.sv */
// Slot pool allocator top level: sequencer plus datapath.
// Flow: no new word is taken until the word in flight commits (req_stall high),
// set by the dependent reads of the block order memory and then the mask and
// generation memories, plus write-back, which waits out a stalled result.
// Reset: synchronous; a clearing pass over all 1024 blocks follows with req_stall high.
// Depends on spa_pkg, spa_ctrl and spa_datapath.
module slot_pool_allocator_with_generations_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_opcode,
   input  logic [spa_pkg::CODE_BITS-1:0]  req_room_code,
   input  logic [spa_pkg::BLOCK_BITS-1:0] req_close_block,
   input  logic [spa_pkg::SLOT_BITS-1:0]  req_close_slot,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [spa_pkg::CODE_BITS-1:0]  csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [spa_pkg::BLOCK_BITS-1:0] rsp_block_index,
   output logic [spa_pkg::SLOT_BITS-1:0]  rsp_slot_index,
   output logic [spa_pkg::GEN_BITS-1:0]   rsp_generation,
   output logic [spa_pkg::CODE_BITS-1:0]  rsp_code_out,
   output logic                          rsp_block_acquired,
   output logic                          rsp_block_released
);
   import spa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   spa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   spa_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_room_code      (req_room_code),
      .req_close_block    (req_close_block),
      .req_close_slot     (req_close_slot),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_block_index    (rsp_block_index),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_generation     (rsp_generation),
      .rsp_code_out       (rsp_code_out),
      .rsp_block_acquired (rsp_block_acquired),
      .rsp_block_released (rsp_block_released)
   );

endmodule
